>>> rtl/tci_pkg.sv
// shared types, constants and helpers of the turtle command interpreter
`timescale 1ns / 1ps

package tci_pkg;

   // command bytes
   localparam logic [7:0] SYM_PUSH  = 8'h5B;  // '['
   localparam logic [7:0] SYM_POP   = 8'h5D;  // ']'
   localparam logic [7:0] SYM_DRAW  = 8'h46;  // 'F'
   localparam logic [7:0] SYM_MOVE  = 8'h66;  // 'f'
   localparam logic [7:0] SYM_RIGHT = 8'h2D;  // '-'
   localparam logic [7:0] SYM_LEFT  = 8'h2B;  // '+'

   // stack fault codes
   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_FULL  = 2'd1,
      FAULT_EMPTY = 2'd2
   } fault_type;

   // configuration register indexes
   localparam logic [1:0] CSR_COS_STEP    = 2'd0;
   localparam logic [1:0] CSR_SIN_STEP    = 2'd1;
   localparam logic [1:0] CSR_STEP_LENGTH = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 23;
   localparam int TRIG_W      = 18;
   localparam int LEN_W       = 23;
   localparam int COORD_W     = 32;
   localparam int WIDE_W      = 36;

   localparam logic signed [TRIG_W-1:0] COS_STEP_RESET    = 18'sd59394;
   localparam logic signed [TRIG_W-1:0] SIN_STEP_RESET    = 18'sd27697;
   localparam logic [LEN_W-1:0]         STEP_LENGTH_RESET = 23'd655360;

   localparam int DEFAULT_STACK_DEPTH = 32;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   // one saved turtle frame
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] hx;
      logic signed [COORD_W-1:0] hy;
   } frame_type;

   // shift controls for the stack chain
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // clamp a wide signed value to the 32-bit coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(COORD_MAX);
      lo = WIDE_W'(COORD_MIN);
      if (v > hi) begin
         return COORD_MAX;
      end else if (v < lo) begin
         return COORD_MIN;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

>>> rtl/turtle_command_interpreter_core.sv
// Turtle command interpreter: one symbol per item, one result per symbol.
// Each symbol has a fix phase, then a commit phase: the first applies the
// start clear and the zero-heading fix and loads the four rotation products
// into registered multipliers, the second sums, rounds and commits the new
// turtle state, which the next symbol depends on. The next symbol is taken
// in the cycle a result is committed; a commit waits while the result
// register stays full. Saved frames live in a chain of STACK_DEPTH
// shift cells whose top is read directly on a pop; the stack needs no
// clearing pass after reset, only its frame count is cleared.
`timescale 1ns / 1ps

module turtle_command_interpreter_core
   import tci_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // symbol
   input  logic                   req_tuser,   // start_new
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [263:0]           rsp_tdata,   // seg_start_x, seg_start_y, seg_end_x,
                                               // seg_end_y, box_min_x, box_min_y,
                                               // box_max_x, box_max_y, stack_fault, zero pad
   output logic                   rsp_tuser,   // drew_line
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   typedef logic signed [COORD_W-1:0] coord_type;

   // configuration registers
   logic signed [TRIG_W-1:0] cos_step_ff, cos_step_in;
   logic signed [TRIG_W-1:0] sin_step_ff, sin_step_in;
   logic [LEN_W-1:0]         step_length_ff, step_length_in;

   // item in flight
   logic       a_valid_ff, a_valid_in;
   logic       phase_ff, phase_in;
   logic [7:0] sym_ff, sym_in;
   logic       start_ff, start_in;

   // turtle state
   coord_type pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   coord_type hx_ff, hx_in, hy_ff, hy_in;
   coord_type low_x_ff, low_x_in, low_y_ff, low_y_in;
   coord_type high_x_ff, high_x_in, high_y_ff, high_y_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      drew_ff, drew_in;
   coord_type sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   coord_type bmin_x_ff, bmin_x_in, bmin_y_ff, bmin_y_in;
   coord_type bmax_x_ff, bmax_x_in, bmax_y_ff, bmax_y_in;
   fault_type fault_ff, fault_in;

   logic          accept, fix_en, commit, out_free;
   coord_type     eff_hx, eff_hy, mv_x, mv_y, rot_hx, rot_hy;
   stack_ctl_type stack_ctl;
   frame_type     live_frame;
   frame_type     cell_q   [STACK_DEPTH];
   frame_type     link_dn  [STACK_DEPTH];
   frame_type     link_up  [STACK_DEPTH];

   function automatic coord_type neg_sat(input coord_type v);
      if (v == COORD_MIN) begin
         return COORD_MAX;
      end
      return -v;
   endfunction

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fix_en     = a_valid_ff && !phase_ff;
   assign commit     = a_valid_ff && phase_ff && out_free;
   assign req_tready = !a_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;

   // heading after start clear and zero-heading fix
   always_comb begin
      eff_hx = start_ff ? '0 : hx_ff;
      eff_hy = start_ff ? '0 : hy_ff;
      if (eff_hx == '0 && eff_hy == '0) begin
         eff_hy = COORD_W'(step_length_ff);
      end
   end

   // saturating move
   assign mv_x = sat_coord(WIDE_W'(pos_x_ff) + WIDE_W'(hx_ff));
   assign mv_y = sat_coord(WIDE_W'(pos_y_ff) + WIDE_W'(hy_ff));

   tci_rotator u_rotator (
      .clock     (clock),
      .load      (fix_en),
      .hx        (eff_hx),
      .hy        (eff_hy),
      .cos_step  (cos_step_ff),
      .sin_step  (sin_step_ff),
      .turn_left (sym_ff == SYM_LEFT),
      .rot_hx    (rot_hx),
      .rot_hy    (rot_hy)
   );

   // stack chain
   assign live_frame = '{px: pos_x_ff, py: pos_y_ff, hx: hx_ff, hy: hy_ff};
   assign stack_ctl.push = commit && sym_ff == SYM_PUSH && count_ff != CNT_FULL;
   assign stack_ctl.pop  = commit && sym_ff == SYM_POP && count_ff != '0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
      if (i == 0) begin : g_top
         assign link_dn[i] = live_frame;
      end else begin : g_mid
         assign link_dn[i] = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign link_up[i] = cell_q[i];
      end else begin : g_upper
         assign link_up[i] = cell_q[i+1];
      end
      tci_stack_cell u_cell (
         .clock      (clock),
         .ctl        (stack_ctl),
         .from_above (link_dn[i]),
         .from_below (link_up[i]),
         .frame_q    (cell_q[i])
      );
   end

   // configuration writes
   always_comb begin
      cos_step_in    = cos_step_ff;
      sin_step_in    = sin_step_ff;
      step_length_in = step_length_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COS_STEP:    cos_step_in    = csr_wdata[TRIG_W-1:0];
            CSR_SIN_STEP:    sin_step_in    = csr_wdata[TRIG_W-1:0];
            CSR_STEP_LENGTH: step_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // next turtle state and result
   always_comb begin
      a_valid_in = a_valid_ff;
      phase_in   = phase_ff;
      sym_in     = sym_ff;
      start_in   = start_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      hx_in      = hx_ff;
      hy_in      = hy_ff;
      low_x_in   = low_x_ff;
      low_y_in   = low_y_ff;
      high_x_in  = high_x_ff;
      high_y_in  = high_y_ff;
      count_in   = count_ff;
      drew_in    = drew_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      ex_in      = ex_ff;
      ey_in      = ey_ff;
      bmin_x_in  = bmin_x_ff;
      bmin_y_in  = bmin_y_ff;
      bmax_x_in  = bmax_x_ff;
      bmax_y_in  = bmax_y_ff;
      fault_in   = fault_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      // fix phase: clear and heading fix
      if (fix_en) begin
         phase_in = 1'b1;
         hx_in    = eff_hx;
         hy_in    = eff_hy;
         if (start_ff) begin
            pos_x_in  = '0;
            pos_y_in  = '0;
            low_x_in  = '0;
            low_y_in  = '0;
            high_x_in = '0;
            high_y_in = '0;
            count_in  = '0;
         end
      end

      // commit phase: execute the symbol and load the result
      if (commit) begin
         phase_in     = 1'b0;
         a_valid_in   = 1'b0;
         rsp_valid_in = 1'b1;
         drew_in      = 1'b0;
         sx_in        = '0;
         sy_in        = '0;
         ex_in        = '0;
         ey_in        = '0;
         fault_in     = FAULT_NONE;
         unique case (sym_ff)
            SYM_PUSH: begin
               if (count_ff == CNT_FULL) begin
                  fault_in = FAULT_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            SYM_POP: begin
               if (count_ff == '0) begin
                  fault_in = FAULT_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  pos_x_in = cell_q[0].px;
                  pos_y_in = cell_q[0].py;
                  hx_in    = cell_q[0].hx;
                  hy_in    = cell_q[0].hy;
               end
            end
            SYM_DRAW, SYM_MOVE: begin
               pos_x_in = mv_x;
               pos_y_in = mv_y;
               if (mv_x < low_x_ff)  low_x_in  = mv_x;
               if (mv_y < low_y_ff)  low_y_in  = mv_y;
               if (mv_x > high_x_ff) high_x_in = mv_x;
               if (mv_y > high_y_ff) high_y_in = mv_y;
               if (sym_ff == SYM_DRAW) begin
                  drew_in = 1'b1;
                  sx_in   = pos_x_ff;
                  sy_in   = neg_sat(pos_y_ff);
                  ex_in   = mv_x;
                  ey_in   = neg_sat(mv_y);
               end
            end
            SYM_RIGHT, SYM_LEFT: begin
               hx_in = rot_hx;
               hy_in = rot_hy;
            end
            default: ;
         endcase
         // box as seen after this symbol, held while the result waits
         bmin_x_in = low_x_in;
         bmin_y_in = low_y_in;
         bmax_x_in = high_x_in;
         bmax_y_in = high_y_in;
      end

      // input capture
      if (accept) begin
         a_valid_in = 1'b1;
         phase_in   = 1'b0;
         sym_in     = req_tdata;
         start_in   = req_tuser;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_step_ff    <= COS_STEP_RESET;
         sin_step_ff    <= SIN_STEP_RESET;
         step_length_ff <= STEP_LENGTH_RESET;
         a_valid_ff     <= 1'b0;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         hx_ff          <= '0;
         hy_ff          <= '0;
         low_x_ff       <= '0;
         low_y_ff       <= '0;
         high_x_ff      <= '0;
         high_y_ff      <= '0;
         count_ff       <= '0;
      end else begin
         cos_step_ff    <= cos_step_in;
         sin_step_ff    <= sin_step_in;
         step_length_ff <= step_length_in;
         a_valid_ff     <= a_valid_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         hx_ff          <= hx_in;
         hy_ff          <= hy_in;
         low_x_ff       <= low_x_in;
         low_y_ff       <= low_y_in;
         high_x_ff      <= high_x_in;
         high_y_ff      <= high_y_in;
         count_ff       <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      start_ff  <= start_in;
      drew_ff   <= drew_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      bmin_x_ff <= bmin_x_in;
      bmin_y_ff <= bmin_y_in;
      bmax_x_ff <= bmax_x_in;
      bmax_y_ff <= bmax_y_in;
      fault_ff  <= fault_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = drew_ff;
   assign rsp_tdata  = {6'b0, fault_ff, bmax_y_ff, bmax_x_ff, bmin_y_ff, bmin_x_ff,
                        ey_ff, ex_ff, sy_ff, sx_ff};

`ifndef ASSERT_OFF
   // frame count never passes the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("frame count beyond stack depth");

   // a taken symbol always holds off the next one through its fix phase
   a_two_cycles: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("symbol accepted in back-to-back cycles");

   // the reported bounding box always holds the origin
   a_box_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (bmin_x_ff <= 0 && bmin_y_ff <= 0 && bmax_x_ff >= 0 && bmax_y_ff >= 0))
      else $error("bounding box lost the origin");

   // no segment fields without a drawn line
   a_seg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !drew_ff) |-> (sx_ff == 0 && sy_ff == 0 && ex_ff == 0 && ey_ff == 0))
      else $error("segment fields set without a line");
`endif

endmodule

>>> rtl/tci_stack_cell.sv
// one frame slot of the shift-register turtle stack
`timescale 1ns / 1ps

module tci_stack_cell
   import tci_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  frame_type     from_above,   // neighbor toward the top (or the live frame)
   input  frame_type     from_below,   // neighbor toward the bottom
   output frame_type     frame_q
);

   frame_type frame_ff;
   frame_type frame_in;

   // push moves frames down one slot, pop moves them up one slot
   always_comb begin
      frame_in = frame_ff;
      if (ctl.push) begin
         frame_in = from_above;
      end else if (ctl.pop) begin
         frame_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame_q = frame_ff;

endmodule

>>> rtl/tci_rotator.sv
// heading rotation: registered products, then sum, round and saturate
`timescale 1ns / 1ps

module tci_rotator
   import tci_pkg::*;
(
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [COORD_W-1:0] hx,
   input  logic signed [COORD_W-1:0] hy,
   input  logic signed [TRIG_W-1:0]  cos_step,
   input  logic signed [TRIG_W-1:0]  sin_step,
   input  logic                      turn_left,
   output logic signed [COORD_W-1:0] rot_hx,
   output logic signed [COORD_W-1:0] rot_hy
);

   localparam int PROD_W = COORD_W + TRIG_W;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [PROD_W-1:0] xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [PROD_W-1:0] xc_in, ys_in, xs_in, yc_in;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   logic signed [SUM_W-1:0]  rnd_x, rnd_y;

   // products of the heading with cosine and sine
   assign xc_in = PROD_W'(hx) * PROD_W'(cos_step);
   assign ys_in = PROD_W'(hy) * PROD_W'(sin_step);
   assign xs_in = PROD_W'(hx) * PROD_W'(sin_step);
   assign yc_in = PROD_W'(hy) * PROD_W'(cos_step);

   always_ff @(posedge clock) begin
      if (load) begin
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
      end
   end

   // sums for a right turn or a left turn
   always_comb begin
      if (turn_left) begin
         sum_x = SUM_W'(xc_ff) + SUM_W'(ys_ff);
         sum_y = SUM_W'(yc_ff) - SUM_W'(xs_ff);
      end else begin
         sum_x = SUM_W'(xc_ff) - SUM_W'(ys_ff);
         sum_y = SUM_W'(xs_ff) + SUM_W'(yc_ff);
      end
   end

   // round half up, floor shift by 16, saturate
   assign rnd_x = (sum_x + SUM_W'(32768)) >>> 16;
   assign rnd_y = (sum_y + SUM_W'(32768)) >>> 16;

   assign rot_hx = sat_coord(rnd_x[WIDE_W-1:0]);
   assign rot_hy = sat_coord(rnd_y[WIDE_W-1:0]);

endmodule

>>> test/tci_monitor.sv
// turtle command interpreter monitor: tracks turtle state and checks every result transfer
`timescale 1ns / 1ps

module tci_monitor
   import tci_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,   // symbol
   input  logic                   req_tuser,   // start_new
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [263:0]           rsp_tdata,   // seg_start_x, seg_start_y, seg_end_x,
                                               // seg_end_y, box_min_x, box_min_y,
                                               // box_max_x, box_max_y, stack_fault, zero pad
   input  logic                   rsp_tuser,   // drew_line
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     errors,
   output int                     waiting,
   output int                     segments,
   output int                     full_faults,
   output int                     empty_faults,
   output int                     clamps
);

   localparam int DEPTH = DEFAULT_STACK_DEPTH;

   typedef logic signed [COORD_W-1:0] coord_type;

   // what one symbol is expected to report
   typedef struct packed {
      logic      drew;
      coord_type seg_sx;
      coord_type seg_sy;
      coord_type seg_ex;
      coord_type seg_ey;
      coord_type lo_x;
      coord_type lo_y;
      coord_type hi_x;
      coord_type hi_y;
      fault_type fault;
   } report_type;

   // local copy of the turtle, its stack, its box and the turn settings
   coord_type                pos_x, pos_y, head_x, head_y;
   coord_type                min_x, min_y, max_x, max_y;
   frame_type                frames [DEPTH];
   int                       depth_used;
   logic signed [TRIG_W-1:0] cos_cfg, sin_cfg;
   logic [LEN_W-1:0]         len_cfg;
   report_type               predicted_reports [$];
   int                       checked;

   function automatic coord_type clamp32(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   // exact sum of two products, rounded half up, back to Q16.16
   function automatic coord_type round_rotate(input longint a, input longint b);
      longint sum;
      sum = (a + b + 64'sd32768) >>> 16;
      return clamp32(sum);
   endfunction

   function automatic void clear_turtle();
      pos_x = '0;
      pos_y = '0;
      head_x = '0;
      head_y = '0;
      min_x = '0;
      min_y = '0;
      max_x = '0;
      max_y = '0;
      depth_used = 0;
   endfunction

   // step along the heading, pin at the coordinate range, widen the box
   function automatic void move_forward();
      longint nx, ny;
      nx = longint'(pos_x) + longint'(head_x);
      ny = longint'(pos_y) + longint'(head_y);
      pos_x = clamp32(nx);
      pos_y = clamp32(ny);
      if (longint'(pos_x) != nx || longint'(pos_y) != ny) clamps++;
      if (pos_x < min_x) min_x = pos_x;
      if (pos_y < min_y) min_y = pos_y;
      if (pos_x > max_x) max_x = pos_x;
      if (pos_y > max_y) max_y = pos_y;
   endfunction

   // apply one symbol to the turtle and work out its report
   function automatic report_type turtle_step(input logic [7:0] sym, input logic start_new);
      report_type r;
      longint     hx, hy, c, s;
      r = '0;
      r.fault = FAULT_NONE;
      if (start_new) clear_turtle();
      // a zero heading restarts along +y at the step length
      if (head_x == 0 && head_y == 0) head_y = coord_type'({9'b0, len_cfg});
      hx = longint'(head_x);
      hy = longint'(head_y);
      c = longint'(cos_cfg);
      s = longint'(sin_cfg);
      case (sym)
         SYM_PUSH: begin
            if (depth_used >= DEPTH) begin
               r.fault = FAULT_FULL;
            end else begin
               frames[depth_used] = '{px: pos_x, py: pos_y, hx: head_x, hy: head_y};
               depth_used++;
            end
         end
         SYM_POP: begin
            if (depth_used == 0) begin
               r.fault = FAULT_EMPTY;
            end else begin
               depth_used--;
               pos_x = frames[depth_used].px;
               pos_y = frames[depth_used].py;
               head_x = frames[depth_used].hx;
               head_y = frames[depth_used].hy;
            end
         end
         SYM_DRAW: begin
            r.drew = 1'b1;
            r.seg_sx = pos_x;
            r.seg_sy = clamp32(-longint'(pos_y));
            move_forward();
            r.seg_ex = pos_x;
            r.seg_ey = clamp32(-longint'(pos_y));
         end
         SYM_MOVE: begin
            move_forward();
         end
         SYM_RIGHT: begin
            head_x = round_rotate(hx * c, -(hy * s));
            head_y = round_rotate(hx * s, hy * c);
         end
         SYM_LEFT: begin
            head_x = round_rotate(hx * c, hy * s);
            head_y = round_rotate(-(hx * s), hy * c);
         end
         default: begin
         end
      endcase
      r.lo_x = min_x;
      r.lo_y = min_y;
      r.hi_x = max_x;
      r.hi_y = max_y;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (errors < 40) $display("result %0d: %s", checked, what);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   // compare one result transfer with the oldest prediction
   task automatic compare_result();
      report_type want;
      if (predicted_reports.size() == 0) begin
         report_mismatch("result arrived with nothing expected");
      end else begin
         want = predicted_reports.pop_front();
         check_field("drew_line", 32'(rsp_tuser), 32'(want.drew));
         check_field("seg_start_x", rsp_tdata[31:0], want.seg_sx);
         check_field("seg_start_y", rsp_tdata[63:32], want.seg_sy);
         check_field("seg_end_x", rsp_tdata[95:64], want.seg_ex);
         check_field("seg_end_y", rsp_tdata[127:96], want.seg_ey);
         check_field("box_min_x", rsp_tdata[159:128], want.lo_x);
         check_field("box_min_y", rsp_tdata[191:160], want.lo_y);
         check_field("box_max_x", rsp_tdata[223:192], want.hi_x);
         check_field("box_max_y", rsp_tdata[255:224], want.hi_y);
         check_field("stack_fault", 32'(rsp_tdata[257:256]), 32'(want.fault));
         if (want.drew) segments++;
         if (want.fault == FAULT_FULL) full_faults++;
         if (want.fault == FAULT_EMPTY) empty_faults++;
      end
      checked++;
   endtask

   // watch the register port and both streams
   always @(posedge clock) begin
      if (reset) begin
         clear_turtle();
         cos_cfg = COS_STEP_RESET;
         sin_cfg = SIN_STEP_RESET;
         len_cfg = STEP_LENGTH_RESET;
         predicted_reports.delete();
         errors = 0;
         checked = 0;
         segments = 0;
         full_faults = 0;
         empty_faults = 0;
         clamps = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COS_STEP:    cos_cfg = csr_wdata[TRIG_W-1:0];
               CSR_SIN_STEP:    sin_cfg = csr_wdata[TRIG_W-1:0];
               CSR_STEP_LENGTH: len_cfg = csr_wdata[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) compare_result();
         if (req_tvalid && req_tready) predicted_reports.push_back(turtle_step(req_tdata, req_tuser));
      end
      waiting = predicted_reports.size();
   end

endmodule

>>> test/tb.sv
// turtle command interpreter testbench top: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
   import tci_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int PHASE_ITEMS   = 200;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int TIMEOUT_NS    = 10_000_000;

   // register index that selects nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;    // symbol
   logic                   req_tuser = 1'b0;  // start_new
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [263:0]           rsp_tdata;         // seg_start_x .. box_max_y, stack_fault, pad
   logic                   rsp_tuser;         // drew_line
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   errors, waiting, segments, full_faults, empty_faults, clamps;
   int   sent = 0;
   logic steady = 1'b0;
   logic hold_req = 1'b0;

   turtle_command_interpreter_core dut (.*);

   tci_monitor u_monitor (.*);

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // command-heavy mix with some arbitrary bytes
   function automatic logic [7:0] random_symbol();
      int r;
      r = $urandom_range(0, 99);
      if (r < 26) return SYM_DRAW;
      if (r < 36) return SYM_MOVE;
      if (r < 50) return SYM_RIGHT;
      if (r < 64) return SYM_LEFT;
      if (r < 76) return SYM_PUSH;
      if (r < 88) return SYM_POP;
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one symbol and wait for its transfer
   task automatic send_symbol(input logic [7:0] sym, input logic start);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      sent++;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering until every result is back and the block is quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // turn and step settings, plus a write to the unused index
   task automatic load_settings(input int cos_val, input int sin_val, input int len_val);
      csr_we <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_index <= CSR_COS_STEP;
      csr_wdata <= CSR_DATA_W'(cos_val);
      @(posedge clock);
      csr_index <= CSR_SIN_STEP;
      csr_wdata <= CSR_DATA_W'(sin_val);
      @(posedge clock);
      csr_index <= CSR_STEP_LENGTH;
      csr_wdata <= CSR_DATA_W'(len_val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // fill the stack past its depth, then empty it past the bottom
   task automatic stack_sweep();
      repeat (34) send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_RIGHT, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      repeat (35) send_symbol(SYM_POP, 1'b0);
   endtask

   // random symbols, branch snippets and occasional deep push or pop runs
   task automatic run_phase(input int quota, input logic with_hold);
      int first;
      int pick;
      int k;
      logic held;
      first = sent;
      held = 1'b0;
      while (sent - first < quota) begin
         pick = $urandom_range(0, 299);
         if (pick < 2) begin
            repeat ($urandom_range(33, 36)) send_symbol(SYM_PUSH, 1'b0);
         end else if (pick < 4) begin
            repeat ($urandom_range(33, 36)) send_symbol(SYM_POP, 1'b0);
         end else if (pick < 40) begin
            k = $urandom_range(1, 3);
            send_symbol(SYM_PUSH, 1'b0);
            send_symbol($urandom_range(0, 1) ? SYM_LEFT : SYM_RIGHT, 1'b0);
            repeat (k) send_symbol(SYM_DRAW, 1'b0);
            send_symbol(SYM_POP, 1'b0);
         end else if (pick < 45) begin
            send_symbol(random_symbol(), 1'b1);
         end else begin
            send_symbol(random_symbol(), 1'b0);
         end
         // result side goes quiet for a long stretch while symbols keep coming
         if (with_hold && !held && sent - first > quota / 3) begin
            hold_req = 1'b1;
            held = 1'b1;
         end
      end
   endtask

   // result side flow control
   initial begin : sink
      int n;
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            for (n = 0; n < LONG_HOLD; n++) @(posedge clock);
         end else if (steady || $urandom_range(0, 99) < 65) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            n = idle_gap();
            if (n == 0) n = 1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, byte extremes, empty pop, start clear
      send_symbol(SYM_DRAW, 1'b1);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_RIGHT, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_LEFT, 1'b0);
      send_symbol(SYM_LEFT, 1'b0);
      send_symbol(SYM_MOVE, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_RIGHT, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_POP, 1'b1);
      send_symbol(SYM_DRAW, 1'b1);
      send_symbol(8'hFF, 1'b1);
      drain();

      // default angle with no idling on either side
      steady = 1'b1;
      run_phase(PHASE_ITEMS, 1'b0);
      steady = 1'b0;
      drain();

      // unit cosine and sine grow the heading until everything pins
      load_settings(65536, 65536, 8388607);
      stack_sweep();
      run_phase(PHASE_ITEMS / 2, 1'b1);
      drain();
      run_phase(PHASE_ITEMS / 2, 1'b0);
      drain();

      load_settings(-65536, -65536, 1);
      run_phase(PHASE_ITEMS, 1'b0);
      drain();

      // zero angle terms collapse the heading, which restarts at the step length
      load_settings(0, 0, $urandom_range(1, 8388607));
      run_phase(PHASE_ITEMS, 1'b0);
      drain();

      repeat (2) begin
         load_settings($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                       $urandom_range(1, 8388607));
         run_phase(PHASE_ITEMS * 3 / 4, 1'b0);
         drain();
      end

      load_settings(int'(COS_STEP_RESET), int'(SIN_STEP_RESET), int'(STEP_LENGTH_RESET));
      run_phase(PHASE_ITEMS / 2, 1'b0);
      drain();

      $display("%0d symbols over seven angle and step settings: %0d segments drawn",
               sent, segments);
      $display("%0d full-stack pushes, %0d empty pops, %0d clamped moves",
               full_faults, empty_faults, clamps);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", waiting);
      $display("Some tests failed");
      $finish;
   end

endmodule
